// ===== src/oahi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_pkg
// Shared types and constants of the open-addressed hash insert block.
// ----------------------------------------------------------------------------
package oahi_pkg;

    localparam int KEY_W    = 31;
    localparam int SLOT_W   = 4;
    localparam int PROBES_W = 5;
    localparam int SIZE_W   = 5;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 5;
    localparam int DH_PRIME = 7;

    // probe modes (code 3 falls back to linear)
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    // configuration register indexes
    localparam logic CFG_PROBE_MODE = 1'b0;
    localparam logic CFG_TABLE_SIZE = 1'b1;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_INVALID  = 2'd2,
        ST_READ     = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd              command;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] read_slot;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [PROBES_W-1:0] probes;
        logic [KEY_W-1:0]    value;
    } t_rsp;

endpackage

// ===== src/oahi_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface oahi_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/open_addressing_hash_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// Open-addressed hash table insert/read engine with linear, quadratic and
// double-hashing probe sequences.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries commands (insert key / read slot), o_rsp one result each.
//   probe_mode and table_size are written on the i_cfg_* port while idle.
//   i_req.ready is high only while the sequencer is idle; one item at a time.
//   Insert: one modular adder first reduces the key mod table size, one key
//   bit per cycle; double hashing then reduces the step mod table size; each
//   probe passes S_PROBE_RD (slot lookup) and S_PROBE_CHK (check and
//   next index through the same adder), with table size capped at
//   min(TABLE_DEPTH, 31) slots. Read passes through S_READ; a zero key
//   goes straight to S_DONE as invalid.
//   A finished result goes to an output register; the sequencer is free to
//   accept the next item while it waits. If the receiver still holds the
//   previous result when the next one finishes, the sequencer waits.
//   Reset (synchronous) empties every slot through per-slot valid bits and
//   loads probe_mode 0, table_size 10.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    oahi_stream_if.sink                  i_req,
    oahi_stream_if.source                o_rsp,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [oahi_pkg::CFG_W-1:0]   i_cfg_wdata
);
    localparam int SW        = oahi_pkg::SIZE_W;
    localparam int KW        = oahi_pkg::KEY_W;
    localparam int SIZE_CAP  = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
    localparam int MEM_DEPTH = SIZE_CAP;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int RD_LIM    = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_REDUCE,
        S_STEP,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [oahi_pkg::MODE_W-1:0] r_mode;
    logic [SW-1:0]               r_tsize;
    logic [SW-1:0]               r_size;
    logic [KW-1:0]               r_key;
    logic [KW-1:0]               r_shf;
    logic [SW-1:0]               r_cnt;
    logic [SW-1:0]               r_acc;
    logic [2:0]                  r_r7;
    logic [2:0]                  r_stp;
    logic [SW-1:0]               r_idx;
    logic [SW-1:0]               r_dd;
    logic [SW-1:0]               r_two;
    logic [SW-1:0]               r_i;
    logic                        r_hit;
    logic [KW-1:0]               r_rdata;
    logic                        r_rdok;
    oahi_pkg::t_rsp              r_st;
    logic                        r_ov;
    oahi_pkg::t_rsp              r_out;

    logic [KW-1:0]               mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]        r_vbits;

    logic [SW-1:0] eff_size;
    logic [SW-1:0] u_a;
    logic [SW-1:0] u_b;
    logic [SW-1:0] u_sum;
    logic [3:0]    t7;
    logic [2:0]    r7_n;
    logic [2:0]    step;
    logic [SW-1:0] w_addr;
    logic          w_we;
    logic          out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;
    assign out_free    = !r_ov || o_rsp.ready;

    // size zero acts as one, sizes above the table saturate
    always_comb begin
        eff_size = r_tsize;
        if (eff_size == '0) begin
            eff_size = SW'(1);
        end
        if (eff_size > SW'(SIZE_CAP)) begin
            eff_size = SW'(SIZE_CAP);
        end
    end

    // running key mod 7, MSB first
    assign t7   = {r_r7, r_shf[KW-1]};
    assign r7_n = (t7 >= 4'(oahi_pkg::DH_PRIME)) ? 3'(t7 - 4'(oahi_pkg::DH_PRIME)) : t7[2:0];
    assign step = 3'(4'(oahi_pkg::DH_PRIME) - {1'b0, r7_n});

    always_comb begin
        unique case (r_state)
            S_REDUCE: begin
                u_a = r_acc;
                u_b = r_acc + {{(SW-1){1'b0}}, r_shf[KW-1]};
            end
            S_STEP: begin
                u_a = r_acc;
                u_b = r_acc + {{(SW-1){1'b0}}, r_stp[2]};
            end
            S_PROBE_RD: begin
                u_a = r_dd;
                u_b = r_two;
            end
            S_PROBE_CHK: begin
                u_a = r_idx;
                u_b = r_dd;
            end
            default: begin
                u_a = '0;
                u_b = '0;
            end
        endcase
    end

    oahi_modadd u_modadd (
        .i_a   (u_a),
        .i_b   (u_b),
        .i_mod (r_size),
        .o_sum (u_sum)
    );

    // table storage: registered read, empty slots tracked by valid bits
    assign w_addr = (r_state == S_IDLE) ? {1'b0, i_req.data.read_slot} : r_idx;
    assign w_we   = (r_state == S_PROBE_CHK) && !r_hit;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_idx[AW-1:0]] <= r_key;
        end
        r_rdata <= mem[w_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
        end else if (w_we) begin
            r_vbits[r_idx[AW-1:0]] <= 1'b1;
        end
        r_hit <= r_vbits[w_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_tsize <= SW'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                oahi_pkg::CFG_PROBE_MODE: r_mode  <= i_cfg_wdata[oahi_pkg::MODE_W-1:0];
                oahi_pkg::CFG_TABLE_SIZE: r_tsize <= i_cfg_wdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ov  <= 1'b1;
                r_out <= r_st;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.data.command == oahi_pkg::CMD_READ) begin
                            r_rdok  <= ({1'b0, i_req.data.read_slot} < SW'(RD_LIM));
                            r_st    <= '{status: oahi_pkg::ST_READ,
                                         slot: i_req.data.read_slot,
                                         probes: '0, value: '0};
                            r_state <= S_READ;
                        end else if (i_req.data.key == '0) begin
                            r_st    <= '{status: oahi_pkg::ST_INVALID,
                                         slot: '0, probes: '0, value: '0};
                            r_state <= S_DONE;
                        end else begin
                            r_key   <= i_req.data.key;
                            r_shf   <= i_req.data.key;
                            r_size  <= eff_size;
                            r_cnt   <= SW'(KW - 1);
                            r_acc   <= '0;
                            r_r7    <= '0;
                            r_i     <= '0;
                            r_dd    <= (eff_size == SW'(1)) ? '0 : SW'(1);
                            r_two   <= (eff_size <= SW'(2)) ? '0 : SW'(2);
                            r_state <= S_REDUCE;
                        end
                    end
                end
                S_READ: begin
                    r_st.value <= (r_rdok && r_hit) ? r_rdata : '0;
                    r_state    <= S_DONE;
                end
                S_REDUCE: begin
                    r_r7  <= r7_n;
                    r_shf <= r_shf << 1;
                    if (r_cnt == '0) begin
                        r_idx <= u_sum;
                        if (r_mode == oahi_pkg::MODE_DOUBLE) begin
                            r_acc   <= '0;
                            r_stp   <= step;
                            r_cnt   <= SW'(2);
                            r_state <= S_STEP;
                        end else begin
                            r_state <= S_PROBE_RD;
                        end
                    end else begin
                        r_acc <= u_sum;
                        r_cnt <= r_cnt - SW'(1);
                    end
                end
                S_STEP: begin
                    r_acc <= u_sum;
                    r_stp <= r_stp << 1;
                    r_cnt <= r_cnt - SW'(1);
                    if (r_cnt == '0) begin
                        r_dd    <= u_sum;
                        r_state <= S_PROBE_RD;
                    end
                end
                S_PROBE_RD: begin
                    // quadratic: delta of probe i is (2i + 1) mod size
                    if (r_mode == oahi_pkg::MODE_QUAD && r_i != '0) begin
                        r_dd <= u_sum;
                    end
                    r_state <= S_PROBE_CHK;
                end
                S_PROBE_CHK: begin
                    if (!r_hit) begin
                        r_st    <= '{status: oahi_pkg::ST_INSERTED,
                                     slot: r_idx[oahi_pkg::SLOT_W-1:0],
                                     probes: r_i + SW'(1), value: '0};
                        r_state <= S_DONE;
                    end else if (r_i == r_size - SW'(1)) begin
                        r_st    <= '{status: oahi_pkg::ST_FULL, slot: '0,
                                     probes: r_size, value: '0};
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= u_sum;
                        r_i     <= r_i + SW'(1);
                        r_state <= S_PROBE_RD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/oahi_modadd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_modadd
// Modular adder: (a + b) mod m, valid when a + b < 2m.
// ----------------------------------------------------------------------------
module oahi_modadd (
    input  logic [oahi_pkg::SIZE_W-1:0] i_a,
    input  logic [oahi_pkg::SIZE_W-1:0] i_b,
    input  logic [oahi_pkg::SIZE_W-1:0] i_mod,
    output logic [oahi_pkg::SIZE_W-1:0] o_sum
);
    logic [oahi_pkg::SIZE_W:0] sum;

    always_comb begin
        sum = {1'b0, i_a} + {1'b0, i_b};
        if (sum >= {1'b0, i_mod}) begin
            o_sum = oahi_pkg::SIZE_W'(sum - {1'b0, i_mod});
        end else begin
            o_sum = sum[oahi_pkg::SIZE_W-1:0];
        end
    end
endmodule

// ===== src/oahi_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_chk
// Port-level checks of the hash insert block, bound to the top level.
// ----------------------------------------------------------------------------
module oahi_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input oahi_pkg::t_rsp i_rsp_data
);
    // result register empties on reset
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled result changed");

    // one item at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready right after input transfer");

    a_insert_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.status == oahi_pkg::ST_INSERTED
        |-> i_rsp_data.probes != '0 && i_rsp_data.value == '0)
        else $error("bad insert result fields");

    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.status == oahi_pkg::ST_READ
        |-> i_rsp_data.probes == '0)
        else $error("read result carries probes");
endmodule

bind open_addressing_hash_insert oahi_chk u_oahi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ===== sim/open_addressing_hash_insert_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_insert_checker
// Watches the request, response and register-write ports of the hash insert
// block, keeps its own copy of the slot table and settings, works out the
// response of each request and compares it field by field with the block.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert_checker
    import oahi_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  t_req             i_req_data,
    input  logic             i_rsp_valid,
    input  logic             i_rsp_ready,
    input  t_rsp             i_rsp_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int MAX_REPORTS = 10;

    logic [KEY_W-1:0]  slot_keys [TABLE_DEPTH];
    logic [MODE_W-1:0] probe_mode;
    logic [SIZE_W-1:0] table_size;
    t_rsp              pending_responses [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Applies one request to the shadow table and returns its response.
    function automatic t_rsp compute_response(t_req req);
        t_rsp            rsp;
        int unsigned     size;
        longint unsigned key_wide;
        longint unsigned step;
        longint unsigned offset;
        longint unsigned idx;
        rsp = '0;
        if (req.command == CMD_READ) begin
            rsp.status = ST_READ;
            rsp.slot   = req.read_slot;
            if (req.read_slot < TABLE_DEPTH)
                rsp.value = slot_keys[req.read_slot];
        end else if (req.key == '0) begin
            rsp.status = ST_INVALID;
        end else begin
            size = (table_size == '0) ? 1 :
                   (table_size > TABLE_DEPTH) ? TABLE_DEPTH : table_size;
            key_wide   = req.key;
            step       = DH_PRIME - (key_wide % DH_PRIME);
            rsp.status = ST_FULL;
            rsp.probes = PROBES_W'(size);
            for (int unsigned i = 0; i < size; i++) begin
                case (probe_mode)
                    MODE_QUAD:   offset = i * i;
                    MODE_DOUBLE: offset = i * step;
                    default:     offset = i;
                endcase
                idx = (key_wide + offset) % size;
                if (slot_keys[idx] == '0) begin
                    slot_keys[idx] = req.key;
                    rsp.status     = ST_INSERTED;
                    rsp.slot       = SLOT_W'(idx);
                    rsp.probes     = PROBES_W'(i + 1);
                    break;
                end
            end
        end
        return rsp;
    endfunction

    task automatic check_response(t_rsp got);
        t_rsp want;
        if (pending_responses.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= MAX_REPORTS)
                $display("%0t: response with none outstanding: status=%0d slot=%0d probes=%0d value=%h",
                         $time, got.status, got.slot, got.probes, got.value);
        end else begin
            want = pending_responses.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.probes !== want.probes || got.value !== want.value) begin
                o_fail_count++;
                if (o_fail_count <= MAX_REPORTS)
                    $display("%0t: mismatch exp status=%0d slot=%0d probes=%0d value=%h | got status=%0d slot=%0d probes=%0d value=%h",
                             $time, want.status, want.slot, want.probes, want.value,
                             got.status, got.slot, got.probes, got.value);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_keys[i])
                slot_keys[i] = '0;
            probe_mode = '0;
            table_size = SIZE_W'(10);
            pending_responses.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROBE_MODE: probe_mode = i_cfg_wdata[MODE_W-1:0];
                    CFG_TABLE_SIZE: table_size = i_cfg_wdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
            // the older request's response is checked before a new one is queued
            if (i_rsp_valid && i_rsp_ready)
                check_response(i_rsp_data);
            if (i_req_valid && i_req_ready)
                pending_responses.push_back(compute_response(i_req_data));
        end
        o_pending = pending_responses.size();
    end

endmodule

// ===== sim/open_addressing_hash_insert_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_insert_tb
// Drives inserts and slot reads into the hash insert block under several
// probe modes and table sizes, with random stalls on both channels; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert_tb;
    import oahi_pkg::*;

    localparam int CLK_PERIOD        = 12;
    localparam int RST_CYCLES        = 12;
    localparam int TABLE_DEPTH       = 16;
    localparam int IDLE_LIMIT        = 4000;
    localparam int DRAIN_CYCLES      = 100;
    localparam int PHASES_PER_REGIME = 8;
    localparam int ITEMS_PER_PHASE   = 30;

    localparam logic [MODE_W-1:0] MODE_LINEAR     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR_ALT = 2'd3;
    localparam logic [KEY_W-1:0]  KEY_MAX         = {KEY_W{1'b1}};

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_wdata;

    int tx_idle_pct;
    int rx_idle_pct;
    int fail_count;
    int pending;
    int quiet_cycles;

    oahi_stream_if #(.T(t_req)) req_if ();
    oahi_stream_if #(.T(t_rsp)) rsp_if ();

    open_addressing_hash_insert #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    open_addressing_hash_insert_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_data   (req_if.data),
        .i_rsp_valid  (rsp_if.valid),
        .i_rsp_ready  (rsp_if.ready),
        .i_rsp_data   (rsp_if.data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // any transfer or register write counts as progress
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("open_addressing_hash_insert_tb NOT OK");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so back-to-back requests follow without a gap.
    task automatic send_request(input t_cmd cmd, input logic [KEY_W-1:0] key,
                                input logic [SLOT_W-1:0] rd_slot);
        t_req item;
        item.command   = cmd;
        item.key       = key;
        item.read_slot = rd_slot;
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input logic [CFG_W-1:0] size);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_PROBE_MODE;
        cfg_wdata <= CFG_W'(mode);
        @(negedge i_clk);
        cfg_idx   <= CFG_TABLE_SIZE;
        cfg_wdata <= size;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_request();
        int unsigned      pick;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(99);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: key = KEY_W'($urandom());
            5, 6, 7:       key = KEY_W'($urandom_range(1, 64));
            default:       key = KEY_MAX - KEY_W'($urandom_range(63));
        endcase
        if (pick < 35)
            send_request(CMD_READ, KEY_W'($urandom()), SLOT_W'($urandom_range(15)));
        else if (pick < 40)
            send_request(CMD_INSERT, '0, SLOT_W'($urandom_range(15)));
        else
            send_request(CMD_INSERT, key, SLOT_W'($urandom_range(15)));
    endtask

    initial begin
        logic [CFG_W-1:0] size;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_PROBE_MODE;
        cfg_wdata    = '0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        quiet_cycles = 0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: linear probing over ten slots
        send_request(CMD_READ, KEY_MAX, 4'd0);
        send_request(CMD_READ, '0, 4'd15);
        send_request(CMD_INSERT, '0, 4'd15);
        send_request(CMD_INSERT, KEY_MAX, 4'd0);
        send_request(CMD_INSERT, KEY_MAX, 4'd0);     // same key lands one slot on
        send_request(CMD_INSERT, 31'd1, 4'd0);
        send_request(CMD_INSERT, 31'd17, 4'd0);      // walks past two taken slots
        send_request(CMD_READ, '0, 4'd7);
        wait_drained();
        configure(MODE_LINEAR, 5'd0);                // size zero acts as one slot
        send_request(CMD_INSERT, 31'd5, 4'd0);
        send_request(CMD_INSERT, 31'd9, 4'd0);       // single slot now taken
        wait_drained();
        configure(MODE_LINEAR_ALT, 5'd31);           // saturates to the full depth
        send_request(CMD_INSERT, 31'd16, 4'd0);
        wait_drained();
        configure(MODE_QUAD, 5'd16);
        send_request(CMD_INSERT, 31'h5555_5555, 4'd0);
        send_request(CMD_INSERT, 31'd21, 4'd0);
        wait_drained();
        configure(MODE_DOUBLE, 5'd13);
        send_request(CMD_INSERT, 31'h2AAA_AAAA, 4'd0);
        send_request(CMD_READ, '0, 4'd12);
        send_request(CMD_READ, KEY_MAX, 4'd15);      // slot beyond the active size

        for (int regime = 0; regime < 3; regime++) begin
            wait_drained();
            case (regime)
                0: begin
                    tx_idle_pct = 21;
                    rx_idle_pct = 81;
                end
                1: begin
                    tx_idle_pct = 81;
                    rx_idle_pct = 21;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int phase = 0; phase < PHASES_PER_REGIME; phase++) begin
                wait_drained();
                case (phase)
                    0:       size = 5'd1;
                    1:       size = 5'd0;
                    2:       size = 5'd16;
                    3:       size = 5'd31;
                    default: size = CFG_W'($urandom_range(31));
                endcase
                configure(MODE_W'(phase % 4), size);
                for (int n = 0; n < ITEMS_PER_PHASE; n++)
                    send_random_request();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("open_addressing_hash_insert_tb OK");
        else
            $display("open_addressing_hash_insert_tb NOT OK");
        $finish;
    end

endmodule
